// ===== hw/rtl/rsa_pkg.sv =====
// shared types and command codes for the modular exponentiation block
package rsa_pkg;

    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRIVATE_EXP = 2'd2;

    localparam int EXP_W = 32;

    // datapath operation codes
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_RBASE  = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_SQR    = 3'd4;
    localparam logic [2:0] OP_RSTEP  = 3'd5;
    localparam logic [2:0] OP_WRITE  = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic       acc_dest;
    } rsa_cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic exp_bit;
        logic exp_last;
        logic red_done;
    } rsa_status_t;

endpackage

// ===== hw/rtl/rsa_datapath.sv =====
// operand registers, multiplier and bit-serial reducer
module rsa_datapath #(
    parameter int MOD_WIDTH = 32
) (
    input  logic                clk,
    input  logic                load_item,
    input  logic [31:0]         value,
    input  logic [31:0]         exponent,
    input  logic [MOD_WIDTH-1:0] modulus,
    input  rsa_pkg::rsa_cmd_t   cmd,
    output rsa_pkg::rsa_status_t status,
    output logic [31:0]         result_value
);
    import rsa_pkg::*;

    // wide enough for a full product and for the whole 32-bit input value
    localparam int PW = (2 * MOD_WIDTH > 32) ? 2 * MOD_WIDTH : 32;
    localparam int CW = $clog2(PW + 1);

    logic [31:0]          exp_reg;
    logic [31:0]          base_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] sq_reg;
    logic [PW-1:0]        prod_reg;
    logic [MOD_WIDTH:0]   rem_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 dest_reg;
    logic                 zero_exp_reg;

    logic [MOD_WIDTH:0]   shifted;
    logic [MOD_WIDTH+1:0] diff;
    logic [MOD_WIDTH-1:0] rem_next;

    // one quotient bit per cycle: shift in next product bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg[MOD_WIDTH-1:0], prod_reg[PW-1]};
        diff     = {1'b0, shifted} - {2'b00, modulus};
        if (!diff[MOD_WIDTH+1])
            rem_next = diff[MOD_WIDTH-1:0];
        else
            rem_next = shifted[MOD_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            exp_reg      <= exponent;
            zero_exp_reg <= (exponent == '0);
            base_reg     <= value;
            acc_reg      <= {{(MOD_WIDTH-1){1'b0}}, 1'b1};
        end
        else
        begin
            case (cmd.op)
                OP_RBASE:
                begin
                    prod_reg <= PW'(base_reg);
                    rem_reg  <= '0;
                    cnt_reg  <= CW'(PW);
                    dest_reg <= 1'b0;
                end
                OP_MUL:
                begin
                    prod_reg <= PW'(acc_reg) * PW'(sq_reg);
                    rem_reg  <= '0;
                    cnt_reg  <= CW'(PW);
                    dest_reg <= 1'b1;
                end
                OP_SQR:
                begin
                    prod_reg <= PW'(sq_reg) * PW'(sq_reg);
                    rem_reg  <= '0;
                    cnt_reg  <= CW'(PW);
                    dest_reg <= 1'b0;
                    exp_reg  <= exp_reg >> 1;
                end
                OP_RSTEP:
                begin
                    if (cnt_reg != '0)
                    begin
                        rem_reg  <= {1'b0, rem_next};
                        prod_reg <= prod_reg << 1;
                        cnt_reg  <= cnt_reg - CW'(1);
                    end
                end
                OP_WRITE:
                begin
                    if (dest_reg)
                        acc_reg <= rem_reg[MOD_WIDTH-1:0];
                    else
                        sq_reg  <= rem_reg[MOD_WIDTH-1:0];
                end
                OP_LOAD:
                begin
                    // reduce the initial accumulator of one
                    prod_reg <= PW'(1);
                    rem_reg  <= '0;
                    cnt_reg  <= CW'(PW);
                    dest_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // a zero modulus leaves the product untouched through subtraction of zero: force zero
    always_comb
    begin
        status.exp_zero = zero_exp_reg;
        status.exp_bit  = exp_reg[0];
        status.exp_last = (exp_reg[31:1] == '0);
        status.red_done = (cnt_reg == '0);
        if (zero_exp_reg)
            result_value = 32'd1;
        else if (modulus == '0)
            result_value = '0;
        else
            result_value = 32'(acc_reg);
    end

endmodule

// ===== hw/rtl/rsa_controller.sv =====
// sequencer for right-to-left square-and-multiply
module rsa_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 load_item,
    output rsa_pkg::rsa_cmd_t    cmd,
    input  rsa_pkg::rsa_status_t status
);
    import rsa_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_ONE   = 4'd2;
    localparam logic [3:0] S_ONEW  = 4'd3;
    localparam logic [3:0] S_BASE  = 4'd4;
    localparam logic [3:0] S_BASEW = 4'd5;
    localparam logic [3:0] S_BIT   = 4'd6;
    localparam logic [3:0] S_MULW  = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_SQRW  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_RED   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // each reduction runs in S_RED, then the write state stored in ret_reg
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cmd.op       = OP_NONE;
        cmd.acc_dest = 1'b0;
        load_item    = 1'b0;
        in_ready     = (state_reg == S_IDLE);
        out_valid    = (state_reg == S_DONE);
        case (state_reg)
            S_IDLE:
            begin
                load_item = in_valid;
                if (in_valid)
                    state_next = S_START;
            end
            S_START:
            begin
                if (status.exp_zero)
                    state_next = S_DONE;
                else
                begin
                    cmd.op     = OP_LOAD;
                    ret_next   = S_ONEW;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                cmd.op = OP_RSTEP;
                if (status.red_done)
                    state_next = ret_reg;
            end
            S_ONEW:
            begin
                cmd.op     = OP_WRITE;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                cmd.op     = OP_RBASE;
                ret_next   = S_BASEW;
                state_next = S_RED;
            end
            S_BASEW:
            begin
                cmd.op     = OP_WRITE;
                state_next = S_BIT;
            end
            S_BIT:
            begin
                if (status.exp_bit)
                begin
                    cmd.op     = OP_MUL;
                    ret_next   = S_MULW;
                    state_next = S_RED;
                end
                else
                    state_next = S_NEXT;
            end
            S_MULW:
            begin
                cmd.op     = OP_WRITE;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (status.exp_last)
                    state_next = S_DONE;
                else
                begin
                    cmd.op     = OP_SQR;
                    ret_next   = S_SQRW;
                    state_next = S_RED;
                end
            end
            S_SQRW:
            begin
                cmd.op     = OP_WRITE;
                state_next = S_BIT;
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.acc_dest = (state_reg == S_MULW);
    end

endmodule

// ===== hw/rtl/rsa_modular_exponentiation.sv =====
// top level of the modular exponentiation block
//
// input channel in_valid/in_ready carries operation and value; one item is
// worked on at a time and in_ready is high only while the block is idle.
// output channel out_valid/out_ready carries result, held until taken.
// operation 0 uses public_exponent, operation 1 private_exponent.
// configuration: cfg_write with cfg_index 0 modulus, 1 public, 2 private
// exponent; write only while no item is in flight.
// right-to-left square-and-multiply with a bit-serial reducer; each modular
// multiply is an issue, one reduction step per product bit and a write-back;
// an exponent of L significant bits needs at most 2*L+1 reductions, counting
// those of the initial accumulator of one and of the base. a zero exponent
// skips the reductions and gives result 1.
// a new item can be taken in the cycle after the result is taken.
// reset loads modulus 143 and exponents 7 and 103 and empties the block.
// a stalled receiver holds the result; no new item is taken until it goes.
module rsa_modular_exponentiation #(
    parameter int MOD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result,
    input  logic        cfg_write,
    input  logic [rsa_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import rsa_pkg::*;

    logic [MOD_WIDTH-1:0] modulus_reg;
    logic [31:0]          pub_exp_reg;
    logic [31:0]          priv_exp_reg;
    logic                 load_item;
    rsa_cmd_t             cmd;
    rsa_status_t          status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= MOD_WIDTH'(143);
            pub_exp_reg  <= 32'd7;
            priv_exp_reg <= 32'd103;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODULUS:     modulus_reg  <= cfg_data[MOD_WIDTH-1:0];
                REG_PUBLIC_EXP:  pub_exp_reg  <= cfg_data;
                REG_PRIVATE_EXP: priv_exp_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rsa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .load_item (load_item),
        .cmd       (cmd),
        .status    (status)
    );

    rsa_datapath #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_dp (
        .clk          (clk),
        .load_item    (load_item),
        .value        (value),
        .exponent     (operation ? priv_exp_reg : pub_exp_reg),
        .modulus      (modulus_reg),
        .cmd          (cmd),
        .status       (status),
        .result_value (result)
    );

endmodule
